FILE: hw/rtl/sfir_pkg.sv
// Package for the stereo FIR filter: request and response payload types,
// field widths, function codes and the MAC control bundle.
// No dependencies; used by every module under hw/rtl.
package sfir_pkg;

   localparam int MAX_TAPS_DEF       = 256;
   localparam int COEF_FRAC_BITS_DEF = 15;

   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 16;
   localparam int COEF_INDEX_W  = 8;
   localparam int TAP_COUNT_W   = 9;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 9'd256;

   localparam logic FUNC_FILTER = 1'b0;
   localparam logic FUNC_COEF   = 1'b1;

   localparam logic CH_LEFT  = 1'b0;
   localparam logic CH_RIGHT = 1'b1;

   typedef struct packed {
      logic                              func;
      logic signed [SAMPLE_W-1:0]        sample_in;
      logic        [COEF_INDEX_W-1:0]    coef_index;
      logic signed [COEF_W-1:0]          coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered_sample;
      logic                       channel;
      logic                       saturated;
   } rsp_type;

   // Control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;          // zero the accumulator
      logic operand_valid;  // history and coefficient read data are valid
      logic finish;         // capture the scaled sum, truncated toward zero
   } mac_ctl_type;

endpackage

FILE: hw/rtl/sfir_coef.sv
// Coefficient memory: one write port, one registered read port.
// Depends on sfir_pkg.
module sfir_coef #(
   parameter int MAX_TAPS = sfir_pkg::MAX_TAPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [sfir_pkg::COEF_INDEX_W-1:0]      wr_index,
   input  logic signed [sfir_pkg::COEF_W-1:0]     wr_data,
   input  logic                                   rd_en,
   input  logic [$clog2(MAX_TAPS)-1:0]            rd_addr,
   output logic signed [sfir_pkg::COEF_W-1:0]     rd_data
);

   localparam int AW = $clog2(MAX_TAPS);

   logic signed [sfir_pkg::COEF_W-1:0] mem [MAX_TAPS];
   logic signed [sfir_pkg::COEF_W-1:0] rd_data_ff;
   logic                               wr_in_range;
   logic [AW-1:0]                      wr_addr;

   // drop writes beyond the last tap
   assign wr_in_range = (32'(wr_index) < MAX_TAPS);
   assign wr_addr     = AW'(wr_index);

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sfir_hist.sv
// Delay lines for both channels as circular buffers in one memory,
// with per-channel write pointers and fill counts. Depends on sfir_pkg.
module sfir_hist #(
   parameter int MAX_TAPS = sfir_pkg::MAX_TAPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ins_valid,
   input  logic                                   ins_channel,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0]   ins_sample,
   input  logic                                   rd_valid,
   input  logic                                   rd_channel,
   input  logic [$clog2(MAX_TAPS)-1:0]            rd_age,
   output logic signed [sfir_pkg::SAMPLE_W-1:0]   rd_data
);

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int TW    = $clog2(MAX_TAPS + 1);
   localparam int DEPTH = 2 * (1 << AW);

   logic signed [sfir_pkg::SAMPLE_W-1:0] mem [DEPTH];

   logic [AW-1:0] ptr_left_ff,  ptr_left_in;
   logic [AW-1:0] ptr_right_ff, ptr_right_in;
   logic [TW-1:0] fill_left_ff,  fill_left_in;
   logic [TW-1:0] fill_right_ff, fill_right_in;
   logic signed [sfir_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                                 rd_zero_ff, rd_zero_in;

   logic [AW-1:0] ins_ptr_cur, ins_ptr_next;
   logic [AW-1:0] rd_ptr;
   logic [TW-1:0] rd_fill;
   logic [AW:0]   rd_diff, rd_pos;

   assign ins_ptr_cur  = (ins_channel == sfir_pkg::CH_RIGHT) ? ptr_right_ff : ptr_left_ff;
   assign ins_ptr_next = (32'(ins_ptr_cur) == MAX_TAPS - 1) ? '0 : ins_ptr_cur + AW'(1);

   // position of a sample 'age' steps back from the newest one, with wrap
   assign rd_ptr  = (rd_channel == sfir_pkg::CH_RIGHT) ? ptr_right_ff : ptr_left_ff;
   assign rd_fill = (rd_channel == sfir_pkg::CH_RIGHT) ? fill_right_ff : fill_left_ff;
   assign rd_diff = {1'b0, rd_ptr} - {1'b0, rd_age};
   assign rd_pos  = rd_diff[AW] ? (rd_diff + (AW+1)'(MAX_TAPS)) : rd_diff;
   // entries past the fill count were never written and read as zero
   assign rd_zero_in = (TW'(rd_age) >= rd_fill);

   always_comb begin
      ptr_left_in   = ptr_left_ff;
      ptr_right_in  = ptr_right_ff;
      fill_left_in  = fill_left_ff;
      fill_right_in = fill_right_ff;
      if (ins_valid) begin
         if (ins_channel == sfir_pkg::CH_RIGHT) begin
            ptr_right_in = ins_ptr_next;
            if (32'(fill_right_ff) < MAX_TAPS) begin
               fill_right_in = fill_right_ff + TW'(1);
            end
         end else begin
            ptr_left_in = ins_ptr_next;
            if (32'(fill_left_ff) < MAX_TAPS) begin
               fill_left_in = fill_left_ff + TW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_left_ff   <= '0;
         ptr_right_ff  <= '0;
         fill_left_ff  <= '0;
         fill_right_ff <= '0;
      end else begin
         ptr_left_ff   <= ptr_left_in;
         ptr_right_ff  <= ptr_right_in;
         fill_left_ff  <= fill_left_in;
         fill_right_ff <= fill_right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_valid) begin
         mem[{ins_channel, ins_ptr_next}] <= ins_sample;
      end
      if (rd_valid) begin
         rd_data_ff <= mem[{rd_channel, rd_pos[AW-1:0]}];
         rd_zero_ff <= rd_zero_in;
      end
   end

   assign rd_data = rd_zero_ff ? '0 : rd_data_ff;

   a_no_insert_during_read: assert property (@(posedge clock) disable iff (reset)
      !(ins_valid && rd_valid))
      else $error("history insert overlaps a tap read");

endmodule

FILE: hw/rtl/sfir_mac.sv
// Multiply-accumulate unit with truncation toward zero and 16-bit saturation.
// Depends on sfir_pkg.
module sfir_mac #(
   parameter int MAX_TAPS       = sfir_pkg::MAX_TAPS_DEF,
   parameter int COEF_FRAC_BITS = sfir_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sfir_pkg::mac_ctl_type                  ctl,
   input  logic signed [sfir_pkg::SAMPLE_W-1:0]   hist_data,
   input  logic signed [sfir_pkg::COEF_W-1:0]     coef_data,
   output logic                                   busy,
   output logic signed [sfir_pkg::SAMPLE_W-1:0]   result,
   output logic                                   saturated
);

   localparam int PW    = sfir_pkg::SAMPLE_W + sfir_pkg::COEF_W;
   localparam int ACC_W = PW + $clog2(MAX_TAPS);

   localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'((1 << COEF_FRAC_BITS) - 1);
   localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

   logic signed [PW-1:0]    prod_ff;
   logic                    prod_valid_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] q_ff, q_in;
   logic signed [ACC_W-1:0] biased;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // add the bias on negative sums so the arithmetic shift truncates toward zero
   assign biased = acc_ff + (acc_ff[ACC_W-1] ? BIAS : '0);
   assign q_in   = biased >>> COEF_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.operand_valid;
      end
      if (ctl.operand_valid) begin
         prod_ff <= hist_data * coef_data;
      end
      acc_ff <= acc_in;
      if (ctl.finish) begin
         q_ff <= q_in;
      end
   end

   always_comb begin
      saturated = 1'b1;
      if (q_ff > Q_MAX) begin
         result = Q_MAX[sfir_pkg::SAMPLE_W-1:0];
      end else if (q_ff < Q_MIN) begin
         result = Q_MIN[sfir_pkg::SAMPLE_W-1:0];
      end else begin
         result    = q_ff[sfir_pkg::SAMPLE_W-1:0];
         saturated = 1'b0;
      end
   end

   assign busy = prod_valid_ff;

endmodule

FILE: hw/rtl/stereo_fir_filter.sv
// Stereo FIR filter, top level. Depends on sfir_pkg, sfir_hist, sfir_coef, sfir_mac.
// Each sample walks taps = tap_count limited to 1..MAX_TAPS, one history/coefficient
//   read per tap; the products are summed by the single MAC, then the scaled sum goes
//   to the response register, held there while rsp_stall is high. A new request
//   waits until the sample is through; a coefficient write gives no result.
// Reset (synchronous): delay lines read as zero, left channel first, tap_count = 256.
module stereo_fir_filter #(
   parameter int MAX_TAPS       = sfir_pkg::MAX_TAPS_DEF,
   parameter int COEF_FRAC_BITS = sfir_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sfir_pkg::req_type                     req_payload,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sfir_pkg::rsp_type                     rsp_payload,
   // tap count register
   input  logic                                  csr_wr_en,
   input  logic [sfir_pkg::TAP_COUNT_W-1:0]      csr_wr_data
);

   localparam int AW = $clog2(MAX_TAPS);
   localparam int TW = $clog2(MAX_TAPS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [AW-1:0]                      age_ff, age_in;
   logic [TW-1:0]                      taps_ff, taps_in;
   logic                               chan_ff, chan_in;
   logic                               next_right_ff, next_right_in;
   logic                               op_valid_ff, op_valid_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   sfir_pkg::rsp_type                  rsp_ff, rsp_in;
   logic [sfir_pkg::TAP_COUNT_W-1:0]   tap_count_ff;

   logic                               req_accept;
   logic                               sample_go;
   logic                               coef_go;
   logic                               rd_valid;
   logic [31:0]                        tc_wide;
   logic [TW-1:0]                      taps_clamped;
   sfir_pkg::mac_ctl_type              mac_ctl;
   logic                               mac_busy;
   logic signed [sfir_pkg::SAMPLE_W-1:0] hist_data;
   logic signed [sfir_pkg::COEF_W-1:0]   coef_data;
   logic signed [sfir_pkg::SAMPLE_W-1:0] mac_result;
   logic                                 mac_saturated;

   // take requests only between samples; a finished result may still wait in rsp_ff
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign sample_go  = req_accept && (req_payload.func == sfir_pkg::FUNC_FILTER);
   assign coef_go    = req_accept && (req_payload.func == sfir_pkg::FUNC_COEF);

   // limit the tap count to 1..MAX_TAPS
   assign tc_wide      = 32'(tap_count_ff);
   assign taps_clamped = (tc_wide == 32'd0)    ? TW'(1) :
                         (tc_wide > MAX_TAPS)  ? TW'(MAX_TAPS) :
                                                 TW'(tc_wide);

   assign rd_valid = (state_ff == ST_RUN);

   always_comb begin
      state_in      = state_ff;
      age_in        = age_ff;
      taps_in       = taps_ff;
      chan_in       = chan_ff;
      next_right_in = next_right_ff;
      op_valid_in   = rd_valid;
      rsp_in        = rsp_ff;
      // drop the held response once taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mac_ctl       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (sample_go) begin
               // insert happens at this edge; clear the accumulator alongside
               mac_ctl.clear = 1'b1;
               age_in        = '0;
               taps_in       = taps_clamped;
               chan_in       = next_right_ff;
               next_right_in = !next_right_ff;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            // one history and coefficient read per cycle, newest sample first
            age_in = age_ff + AW'(1);
            if (TW'(age_ff) == taps_ff - TW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to land in the accumulator, then truncate toward zero
            if (!op_valid_ff && !mac_busy) begin
               mac_ctl.finish = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.filtered_sample = mac_result;
               rsp_in.channel         = chan_ff;
               rsp_in.saturated       = mac_saturated;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      mac_ctl.operand_valid = op_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_right_ff <= sfir_pkg::CH_LEFT;
         op_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tap_count_ff  <= sfir_pkg::TAP_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         next_right_ff <= next_right_in;
         op_valid_ff   <= op_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            tap_count_ff <= csr_wr_data;
         end
      end
      age_ff  <= age_in;
      taps_ff <= taps_in;
      chan_ff <= chan_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // per-channel delay lines
   sfir_hist #(
      .MAX_TAPS (MAX_TAPS)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .ins_valid   (sample_go),
      .ins_channel (next_right_ff),
      .ins_sample  (req_payload.sample_in),
      .rd_valid    (rd_valid),
      .rd_channel  (chan_ff),
      .rd_age      (age_ff),
      .rd_data     (hist_data)
   );

   // coefficient store, addressed by tap
   sfir_coef #(
      .MAX_TAPS (MAX_TAPS)
   ) u_coef (
      .clock    (clock),
      .wr_en    (coef_go),
      .wr_index (req_payload.coef_index),
      .wr_data  (req_payload.coef_value),
      .rd_en    (rd_valid),
      .rd_addr  (age_ff),
      .rd_data  (coef_data)
   );

   // one multiply-accumulate per tap
   sfir_mac #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .hist_data (hist_data),
      .coef_data (coef_data),
      .busy      (mac_busy),
      .result    (mac_result),
      .saturated (mac_saturated)
   );

   a_age_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (TW'(age_ff) < taps_ff))
      else $error("tap walk past the tap count");

   a_taps_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (taps_ff != '0) && (32'(taps_ff) <= MAX_TAPS))
      else $error("tap count outside 1..MAX_TAPS");

   a_operand_from_run: assert property (@(posedge clock) disable iff (reset)
      op_valid_ff |-> $past(state_ff == ST_RUN))
      else $error("MAC operand without a tap read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response loaded outside the done state");

endmodule
